// File: design/glzw_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW packer package
// Shared widths, register indexes, command and status types and helpers.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int MAX_PIXELS_BITS = 24;
  localparam int PIXEL_COUNT_W   = 24;
  localparam int DIV_W           = (MAX_PIXELS_BITS < PIXEL_COUNT_W) ?
                                   MAX_PIXELS_BITS : PIXEL_COUNT_W;
  localparam int CNT_W           = $clog2(DIV_W + 1);
  localparam int CS_W            = 4;
  localparam int PIX_W           = 8;
  localparam int CODE_W          = 9;
  localparam int BUF_W           = 16;
  localparam int FILL_W          = 5;
  localparam int GRP_W           = 8;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = PIXEL_COUNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_SIZE   = 1'b0,
    REG_PIXEL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_OPEN,
    OP_CLEAR,
    OP_STOP,
    OP_LIT,
    OP_FLUSH
  } code_op_t;

  typedef struct packed {
    logic     load_item;
    code_op_t op;
    logic     extract;
    logic     rel;
  } glzw_cmd_t;

  typedef struct packed {
    logic started;
    logic eoi;
    logic group_zero;
    logic fill_ge8;
    logic fill_nz;
    logic held_valid;
    logic out_free;
    logic mod_busy;
  } glzw_sts_t;

  function automatic logic [CS_W-1:0] eff_size(input logic [CS_W-1:0] cs);
    logic [CS_W-1:0] r;
    if (cs == CS_W'(0)) begin
      r = CS_W'(1);
    end else if (cs > CS_W'(8)) begin
      r = CS_W'(8);
    end else begin
      r = cs;
    end
    return r;
  endfunction

  function automatic logic [GRP_W-1:0] interval_of(input logic [CS_W-1:0] cs);
    logic [CODE_W-1:0] v;
    v = (CODE_W'(1) << cs) - CODE_W'(2);
    if (v == CODE_W'(0)) begin
      v = CODE_W'(1);
    end
    return v[GRP_W-1:0];
  endfunction

endpackage

// File: design/glzw_ifs.sv
// ----------------------------------------------------------------------------
// GIF LZW packer channel interfaces
// Valid/ready channels for pixel words and packed byte words.
// ----------------------------------------------------------------------------
interface glzw_in_if import glzw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             end_of_image;

  modport source (output valid, output pixel, output end_of_image, input ready);
  modport sink   (input valid, input pixel, input end_of_image, output ready);
endinterface

interface glzw_out_if import glzw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_byte;
  logic             run_end;
  logic             stream_end;

  modport source (output valid, output out_byte, output run_end, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input stream_end,
                  output ready);
endinterface

// File: design/glzw_mod.sv
// ----------------------------------------------------------------------------
// GIF LZW packer remainder unit
// Restoring bit-serial remainder of the pixel count by the group interval.
// ----------------------------------------------------------------------------
module glzw_mod import glzw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [GRP_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [GRP_W-1:0] rem
);

  logic [DIV_W-1:0] q_r;
  logic [GRP_W-1:0] rem_r, rem_nxt, div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [GRP_W:0]   trial, diff;

  always_comb begin
    trial = {rem_r, q_r[DIV_W-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[GRP_W-1:0];
    end else begin
      rem_nxt = trial[GRP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= CNT_W'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: design/glzw_dp.sv
// ----------------------------------------------------------------------------
// GIF LZW packer datapath
// Configuration registers, bit buffer, group counter and byte output stage.
// ----------------------------------------------------------------------------
module glzw_dp import glzw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  end_of_image,
  input  glzw_cmd_t             cmd,
  output glzw_sts_t             sts,
  glzw_out_if.source            out_m
);

  logic [CS_W-1:0]          code_size_r;
  logic [PIXEL_COUNT_W-1:0] pixel_count_r;
  logic [PIX_W-1:0]         pixel_r;
  logic                     eoi_r;
  logic [BUF_W-1:0]         buffer_r, buffer_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt, width;
  logic [GRP_W-1:0]         group_r, group_nxt, grp_rem;
  logic                     started_r, started_nxt;
  logic [PIX_W-1:0]         held_r, out_byte_r, lit_mask;
  logic                     held_valid_r, out_valid_r, run_end_r, stream_end_r;
  logic [CS_W-1:0]          cs;
  logic [CODE_W-1:0]        clear_code, code;
  logic                     push, mod_busy, mod_done, out_free;

  glzw_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_OPEN),
    .dividend (pixel_count_r[DIV_W-1:0]),
    .divisor  (interval_of(cs)),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (grp_rem)
  );

  always_comb begin
    cs         = eff_size(code_size_r);
    width      = FILL_W'(cs) + FILL_W'(1);
    clear_code = CODE_W'(1) << cs;
    lit_mask   = PIX_W'((CODE_W'(1) << cs) - CODE_W'(1));
    push       = 1'b1;
    unique case (cmd.op)
      OP_OPEN, OP_CLEAR: code = clear_code;
      OP_STOP:           code = clear_code + CODE_W'(1);
      OP_LIT:            code = {1'b0, pixel_r & lit_mask};
      default: begin
        code = '0;
        push = 1'b0;
      end
    endcase

    buffer_nxt = buffer_r;
    fill_nxt   = fill_r;
    if (cmd.extract) begin
      buffer_nxt = buffer_r >> 8;
      fill_nxt   = fill_r - FILL_W'(8);
    end
    if (push) begin
      buffer_nxt = buffer_r | (BUF_W'(code) << fill_r);
      fill_nxt   = fill_r + width;
    end
    if (cmd.op == OP_FLUSH) begin
      buffer_nxt = '0;
      fill_nxt   = '0;
    end

    group_nxt   = group_r;
    started_nxt = started_r;
    priority if (mod_done) begin
      group_nxt = grp_rem;
    end else if (cmd.op == OP_CLEAR) begin
      group_nxt = interval_of(cs);
    end else if (cmd.op == OP_LIT) begin
      group_nxt = group_r - GRP_W'(1);
    end else if (cmd.op == OP_FLUSH) begin
      group_nxt = '0;
    end
    if (cmd.op == OP_OPEN) begin
      started_nxt = 1'b1;
    end else if (cmd.op == OP_FLUSH) begin
      started_nxt = 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_m.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_size_r   <= CS_W'(8);
      pixel_count_r <= '0;
      buffer_r      <= '0;
      fill_r        <= '0;
      group_r       <= '0;
      started_r     <= 1'b0;
      held_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CODE_SIZE:   code_size_r   <= cfg_data[CS_W-1:0];
          REG_PIXEL_COUNT: pixel_count_r <= cfg_data[PIXEL_COUNT_W-1:0];
        endcase
      end
      if (cmd.load_item) begin
        pixel_r <= pixel;
        eoi_r   <= end_of_image;
      end
      buffer_r  <= buffer_nxt;
      fill_r    <= fill_nxt;
      group_r   <= group_nxt;
      started_r <= started_nxt;
      if (cmd.extract) begin
        if (held_valid_r) begin
          out_byte_r   <= held_r;
          run_end_r    <= 1'b0;
          stream_end_r <= 1'b0;
          out_valid_r  <= 1'b1;
        end else if (out_m.ready) begin
          out_valid_r <= 1'b0;
        end
        held_r       <= buffer_r[PIX_W-1:0];
        held_valid_r <= 1'b1;
      end else if (cmd.rel) begin
        out_byte_r   <= held_r;
        run_end_r    <= 1'b1;
        stream_end_r <= eoi_r;
        out_valid_r  <= 1'b1;
        held_valid_r <= 1'b0;
      end else if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.out_byte   = out_byte_r;
  assign out_m.run_end    = run_end_r;
  assign out_m.stream_end = stream_end_r;

  assign sts.started    = started_r;
  assign sts.eoi        = eoi_r;
  assign sts.group_zero = (group_r == '0);
  assign sts.fill_ge8   = (fill_r >= FILL_W'(8));
  assign sts.fill_nz    = (fill_r != '0);
  assign sts.held_valid = held_valid_r;
  assign sts.out_free   = out_free;
  assign sts.mod_busy   = mod_busy;

endmodule

// File: design/glzw_ctrl.sv
// ----------------------------------------------------------------------------
// GIF LZW packer controller
// Sequences the codes of one word and drains the bit buffer into bytes.
// ----------------------------------------------------------------------------
module glzw_ctrl import glzw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  glzw_sts_t sts,
  output glzw_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_MODW,
    S_BODY,
    S_DRAIN,
    S_FLUSH,
    S_FIN
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   can_move;

  assign can_move = !sts.held_valid || sts.out_free;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cmd.load_item = 1'b0;
    cmd.op        = OP_NONE;
    cmd.extract   = 1'b0;
    cmd.rel       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = sts.started ? S_BODY : S_OPEN;
        end
      end
      S_OPEN: begin
        cmd.op    = OP_OPEN;
        ret_nxt   = S_MODW;
        state_nxt = S_DRAIN;
      end
      S_MODW: begin
        if (!sts.mod_busy) begin
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        state_nxt = S_DRAIN;
        priority if (sts.eoi) begin
          cmd.op  = OP_STOP;
          ret_nxt = S_FLUSH;
        end else if (sts.group_zero) begin
          cmd.op  = OP_CLEAR;
          ret_nxt = S_BODY;
        end else begin
          cmd.op  = OP_LIT;
          ret_nxt = S_FIN;
        end
      end
      S_DRAIN: begin
        if (!sts.fill_ge8) begin
          state_nxt = ret_r;
        end else if (can_move) begin
          cmd.extract = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!sts.fill_nz || can_move) begin
          cmd.op      = OP_FLUSH;
          cmd.extract = sts.fill_nz;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.held_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.rel   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: design/gif_uncompressed_lzw_packer.sv
// ----------------------------------------------------------------------------
// GIF uncompressed LZW packer
// Turns colour indices into GIF LZW bytes of clear, stop and literal codes.
//
// Pixel words enter on in_s (pixel, end_of_image) and packed byte words leave
// on out_m (out_byte, run_end, stream_end); both are valid/ready channels.
// The cfg_ port writes code_size (index 0) and pixel_count (index 1); the user
// must write them only while the block is idle, which the block does not
// enforce. A word is taken only in the idle state, then the controller pushes
// its codes one at a time into a 16-bit bit buffer and, after each code, drains
// full bytes one per cycle while the output can take them. A clear code goes
// before the literal when the group counter is zero, and an end word sends the
// stop code and flushes the remaining bits. The first word of an image also
// sends the opening clear code and runs the bit-serial remainder unit for the
// first group length. The last byte of a word is held back one stage so that
// it can carry run_end. A stalled receiver holds the output register and then
// the held byte, and the block waits when both are full. Reset empties the bit
// buffer, marks no image as started and sets code_size to 8, pixel_count to 0.
// ----------------------------------------------------------------------------
module gif_uncompressed_lzw_packer import glzw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  glzw_in_if.sink               in_s,
  glzw_out_if.source            out_m
);

  glzw_cmd_t cmd;
  glzw_sts_t sts;
  logic      in_ready;

  glzw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  glzw_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (in_s.pixel),
    .end_of_image (in_s.end_of_image),
    .cmd          (cmd),
    .sts          (sts),
    .out_m        (out_m)
  );

  assign in_s.ready = in_ready;

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready) |=> !in_s.ready)
    else $error("word accepted on two consecutive cycles");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.ready |-> (!sts.held_valid && !sts.fill_ge8 && !sts.mod_busy))
    else $error("idle with bytes or remainder work pending");

  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_m.valid && out_m.stream_end) |-> out_m.run_end)
    else $error("stream end byte without run end");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.extract && sts.held_valid) |-> sts.out_free)
    else $error("held byte moved into an occupied output register");

endmodule
